// ===== hw/rtl/refract_direction_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Refraction direction unit assertion macros
// Shared concurrent assertion forms for the refraction direction unit.
// ---------------------------------------------------------------------------
`ifndef REFRACT_DIRECTION_UNIT_DEFINES_SVH
`define REFRACT_DIRECTION_UNIT_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define RDU_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("refraction unit assertion failed");

// The property must hold in the cycle after the condition.
`define RDU_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("refraction unit assertion failed");

`endif

// ===== hw/rtl/rdu_pkg.sv =====
// ---------------------------------------------------------------------------
// Refraction direction unit package
// Payload types, cell state types and chain lengths shared by the unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rdu_pkg;

  // Cells in the relative index divider (one quotient bit each).
  localparam int unsigned RecipSteps = 32;
  // Cells in each square root chain (one root bit each).
  localparam int unsigned SqrtSteps = 32;
  // Cells in each output divider; the quotient never exceeds 2^14.
  localparam int unsigned NormDivSteps = 15;
  // Leading zero stages of the normalizer: shifts of 32, 16, 8, 4, 2 and 1.
  localparam int unsigned NormStages = 6;

  // One incoming ray.
  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        index_incident;
    logic [15:0]        index_transmit;
  } ray_t;

  // One refracted direction.
  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               valid_res;
  } res_t;

  // State passed between restoring divider cells.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] den;
    logic [31:0] num;
    logic [31:0] quo;
  } div_t;

  // State passed between square root cells.
  typedef struct packed {
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_t;

endpackage

`default_nettype wire

// ===== hw/rtl/refract_direction_unit.sv =====
// ---------------------------------------------------------------------------
// Refraction direction unit
// Refracts a ray at a surface by the vector form of Snell's law and returns
// the unit transmitted direction, or a zero vector on total internal
// reflection or a zero transmit index.
// ---------------------------------------------------------------------------
//   channel | valid     | stall     | payload | moves
//   input   | ray_valid | ray_stall | ray     | normal, direction, indices
//   output  | res_valid | res_stall | res     | refracted direction, flag
//
// One transfer is taken per cycle unless a valid output is stalled; a result
// passes through the divider, square root and normalizer chains and the stages between.
// Reset (rst, synchronous) empties the pipeline; no data is cleared.
// A stall on a valid output freezes every stage and stalls the input in turn.
// ---------------------------------------------------------------------------
`default_nettype none

module refract_direction_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          ray_valid,
  output logic          ray_stall,
  input  rdu_pkg::ray_t ray,
  output logic          res_valid,
  input  logic          res_stall,
  output rdu_pkg::res_t res
);

  localparam int unsigned RL = rdu_pkg::RecipSteps - 1;
  localparam int unsigned SL = rdu_pkg::SqrtSteps - 1;
  localparam int unsigned DL = rdu_pkg::NormDivSteps - 1;
  localparam int unsigned NS = rdu_pkg::NormStages;

  typedef struct packed {
    logic [2:0][15:0] n;
    logic [2:0][15:0] d;
    logic             itz;
  } geo_t;

  typedef struct packed {
    logic signed [36:0] rc;
    logic [15:0]        r;
    logic [2:0][15:0]   n;
    logic [2:0][15:0]   d;
    logic               bad;
  } mid_t;

  typedef struct packed {
    logic [62:0]      m;
    logic [2:0][62:0] mag;
    logic [2:0]       sgn;
    logic             bad;
    logic             zero;
  } norm_t;

  typedef struct packed {
    logic [2:0][29:0] mg;
    logic [2:0]       sgn;
    logic             bad;
    logic             zero;
  } fin_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic       bad;
    logic       zero;
  } tag_t;

  logic adv;

  // Valid bits of every stage.
  logic [RL:0] v1;
  logic [7:0]  vh;
  logic [SL:0] v2;
  logic [4:0]  vi;
  logic [NS-1:0] vn;
  logic [1:0]  vo;
  logic [SL:0] v3;
  logic        vp;
  logic [DL:0] v4;

  // The whole pipeline moves unless a finished result is held back.
  assign adv       = !(res_valid && res_stall);
  assign ray_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= '0;
      vh        <= '0;
      v2        <= '0;
      vi        <= '0;
      vn        <= '0;
      vo        <= '0;
      v3        <= '0;
      vp        <= 1'b0;
      v4        <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= {v1[RL-1:0], ray_valid};
      vh        <= {vh[6:0], v1[RL]};
      v2        <= {v2[SL-1:0], vh[7]};
      vi        <= {vi[3:0], v2[SL]};
      vn        <= {vn[NS-2:0], vi[4]};
      vo        <= {vo[0], vn[NS-1]};
      v3        <= {v3[SL-1:0], vo[1]};
      vp        <= v3[SL];
      v4        <= {v4[DL-1:0], vp};
      res_valid <= v4[DL];
    end
  end

  // Relative index divider chain: index_incident * 4096 / index_transmit.
  rdu_pkg::div_t rq_in [rdu_pkg::RecipSteps];
  rdu_pkg::div_t rq    [rdu_pkg::RecipSteps];
  geo_t          geo1  [rdu_pkg::RecipSteps];
  geo_t          ray_geo;

  always_comb begin
    ray_geo.n   = {ray.normal_z, ray.normal_y, ray.normal_x};
    ray_geo.d   = {ray.dir_z, ray.dir_y, ray.dir_x};
    ray_geo.itz = (ray.index_transmit == 16'd0);
    rq_in[0]    = '{rem: 32'd0, den: {16'd0, ray.index_transmit},
                    num: {4'd0, ray.index_incident, 12'd0}, quo: 32'd0};
    for (int i = 1; i < rdu_pkg::RecipSteps; i++) begin
      rq_in[i] = rq[i-1];
    end
  end

  for (genvar i = 0; i < rdu_pkg::RecipSteps; i++) begin : g_recip
    rdu_div_cell u_cell (.clk(clk), .en(adv), .din(rq_in[i]), .dout(rq[i]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo1[0] <= ray_geo;
      for (int i = 1; i < rdu_pkg::RecipSteps; i++) begin
        geo1[i] <= geo1[i-1];
      end
    end
  end

  // Stages from the dot product to k = 2^40 - r * floor(r * t / 2^12).
  logic [15:0]        s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r;
  logic signed [31:0] s1_pd [3];
  geo_t               s1_geo, s2_geo, s3_geo, s4_geo, s5_geo, s6_geo, s7_geo;
  logic signed [19:0] s2_c;
  logic signed [39:0] s3_cc;
  logic signed [36:0] s3_rc, s4_rc, s5_rc, s6_rc, s7_rc;
  logic signed [40:0] s4_tt;
  logic signed [37:0] s5_ph, s5_pl;
  logic signed [45:0] s6_ff;
  logic signed [42:0] s7_qh;
  logic signed [37:0] s7_ql;
  logic signed [63:0] s8_k;
  mid_t               s8_mid;
  logic signed [33:0] ni;
  logic signed [57:0] rt;
  logic signed [63:0] pp;
  logic signed [63:0] kk;

  always_comb begin
    ni = -(34'(s1_pd[0]) + 34'(s1_pd[1]) + 34'(s1_pd[2]));
    rt = (58'(s5_ph) <<< 20) + 58'(s5_pl);
    pp = (64'(s7_qh) <<< 20) + 64'(s7_ql);
    kk = 64'sd1099511627776 - pp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Saturate r and form the three products of n and d.
      s1_r   <= (rq[RL].quo[31:16] != 16'd0) ? 16'hFFFF : rq[RL].quo[15:0];
      for (int i = 0; i < 3; i++) begin
        s1_pd[i] <= $signed(geo1[RL].n[i]) * $signed(geo1[RL].d[i]);
      end
      s1_geo <= geo1[RL];
      // Cosine term c = floor(-(n.d) / 2^14).
      s2_r   <= s1_r;
      s2_c   <= ni[33:14];
      s2_geo <= s1_geo;
      // c squared and r times c.
      s3_r   <= s2_r;
      s3_cc  <= s2_c * s2_c;
      s3_rc  <= $signed({1'b0, s2_r}) * s2_c;
      s3_geo <= s2_geo;
      // t = 2^28 - c^2.
      s4_r   <= s3_r;
      s4_tt  <= 41'sd268435456 - 41'(s3_cc);
      s4_rc  <= s3_rc;
      s4_geo <= s3_geo;
      // r * t as two partial products.
      s5_r   <= s4_r;
      s5_ph  <= $signed({1'b0, s4_r}) * $signed(s4_tt[40:20]);
      s5_pl  <= $signed({1'b0, s4_r}) * $signed({1'b0, s4_tt[19:0]});
      s5_rc  <= s4_rc;
      s5_geo <= s4_geo;
      // Sum the partials and drop twelve fraction bits.
      s6_r   <= s5_r;
      s6_ff  <= rt[57:12];
      s6_rc  <= s5_rc;
      s6_geo <= s5_geo;
      // r times the scaled product, again in two parts.
      s7_r   <= s6_r;
      s7_qh  <= $signed({1'b0, s6_r}) * $signed(s6_ff[45:20]);
      s7_ql  <= $signed({1'b0, s6_r}) * $signed({1'b0, s6_ff[19:0]});
      s7_rc  <= s6_rc;
      s7_geo <= s6_geo;
      // k and the reject flag.
      s8_k   <= kk;
      s8_mid <= '{rc: s7_rc, r: s7_r, n: s7_geo.n, d: s7_geo.d,
                  bad: s7_geo.itz | kk[63]};
    end
  end

  // Square root chain for sqrt(k).
  rdu_pkg::sqrt_t sq2_in [rdu_pkg::SqrtSteps];
  rdu_pkg::sqrt_t sq2    [rdu_pkg::SqrtSteps];
  mid_t           sb2    [rdu_pkg::SqrtSteps];

  always_comb begin
    sq2_in[0] = '{rad: s8_k, rem: 35'd0, root: 32'd0};
    for (int i = 1; i < rdu_pkg::SqrtSteps; i++) begin
      sq2_in[i] = sq2[i-1];
    end
  end

  for (genvar i = 0; i < rdu_pkg::SqrtSteps; i++) begin : g_sqrt_k
    rdu_sqrt_cell u_cell (.clk(clk), .en(adv), .din(sq2_in[i]), .dout(sq2[i]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb2[0] <= s8_mid;
      for (int i = 1; i < rdu_pkg::SqrtSteps; i++) begin
        sb2[i] <= sb2[i-1];
      end
    end
  end

  // Unnormalized refracted vector v = n * a + d * r * 2^14.
  logic signed [39:0] s9_a;
  mid_t               s9_mid;
  logic signed [35:0] s10_nh [3];
  logic signed [36:0] s10_nl [3];
  logic signed [32:0] s10_dr [3];
  logic               s10_bad, s11_bad, s12_bad;
  logic signed [57:0] s11_v  [3];
  logic [56:0]        s12_mag [3];
  logic [2:0]         s12_sgn;
  logic [56:0]        mx;
  norm_t              nrm [NS+1];

  always_comb begin
    mx = s12_mag[0];
    if (s12_mag[1] > mx) begin
      mx = s12_mag[1];
    end
    if (s12_mag[2] > mx) begin
      mx = s12_mag[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // a = r * c - sqrt(k) * 2^6.
      s9_a    <= 40'(sb2[SL].rc) - $signed({2'b00, sq2[SL].root, 6'd0});
      s9_mid  <= sb2[SL];
      // Partial products of each lane.
      for (int i = 0; i < 3; i++) begin
        s10_nh[i] <= $signed(s9_mid.n[i]) * $signed(s9_a[39:20]);
        s10_nl[i] <= $signed(s9_mid.n[i]) * $signed({1'b0, s9_a[19:0]});
        s10_dr[i] <= $signed(s9_mid.d[i]) * $signed({1'b0, s9_mid.r});
      end
      s10_bad <= s9_mid.bad;
      // Lane sums.
      for (int i = 0; i < 3; i++) begin
        s11_v[i] <= (58'(s10_nh[i]) <<< 20) + 58'(s10_nl[i]) + (58'(s10_dr[i]) <<< 14);
      end
      s11_bad <= s10_bad;
      // Sign and magnitude.
      for (int i = 0; i < 3; i++) begin
        s12_mag[i] <= s11_v[i][57] ? 57'(-s11_v[i]) : s11_v[i][56:0];
        s12_sgn[i] <= s11_v[i][57];
      end
      s12_bad <= s11_bad;
      // Largest magnitude starts the normalizer.
      nrm[0].m    <= 63'(mx);
      for (int i = 0; i < 3; i++) begin
        nrm[0].mag[i] <= 63'(s12_mag[i]);
      end
      nrm[0].sgn  <= s12_sgn;
      nrm[0].bad  <= s12_bad;
      nrm[0].zero <= (mx == 57'd0);
    end
  end

  // Normalizer: shift left until the largest magnitude has its top bit set.
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int unsigned Sh = 1 << (NS - 1 - j);
    logic lead_zero;

    assign lead_zero = (nrm[j].m[62 -: Sh] == '0);

    always_ff @(posedge clk) begin
      if (adv) begin
        nrm[j+1].m <= lead_zero ? (nrm[j].m << Sh) : nrm[j].m;
        for (int i = 0; i < 3; i++) begin
          nrm[j+1].mag[i] <= lead_zero ? (nrm[j].mag[i] << Sh) : nrm[j].mag[i];
        end
        nrm[j+1].sgn  <= nrm[j].sgn;
        nrm[j+1].bad  <= nrm[j].bad;
        nrm[j+1].zero <= nrm[j].zero;
      end
    end
  end

  // Squared length of the normalized vector.
  logic [2:0][29:0] s14_mg;
  logic [59:0]      s14_sq [3];
  tag_t             s14_tag;
  logic [61:0]      s15_sum;
  fin_t             s15_fin;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s14_mg[i] <= nrm[NS].mag[i][62:33];
        s14_sq[i] <= nrm[NS].mag[i][62:33] * nrm[NS].mag[i][62:33];
      end
      s14_tag <= '{sgn: nrm[NS].sgn, bad: nrm[NS].bad, zero: nrm[NS].zero};
      s15_sum <= 62'(s14_sq[0]) + 62'(s14_sq[1]) + 62'(s14_sq[2]);
      s15_fin <= '{mg: s14_mg, sgn: s14_tag.sgn, bad: s14_tag.bad, zero: s14_tag.zero};
    end
  end

  // Square root chain for the vector length.
  rdu_pkg::sqrt_t sq3_in [rdu_pkg::SqrtSteps];
  rdu_pkg::sqrt_t sq3    [rdu_pkg::SqrtSteps];
  fin_t           sb3    [rdu_pkg::SqrtSteps];

  always_comb begin
    sq3_in[0] = '{rad: {2'b00, s15_sum}, rem: 35'd0, root: 32'd0};
    for (int i = 1; i < rdu_pkg::SqrtSteps; i++) begin
      sq3_in[i] = sq3[i-1];
    end
  end

  for (genvar i = 0; i < rdu_pkg::SqrtSteps; i++) begin : g_sqrt_len
    rdu_sqrt_cell u_cell (.clk(clk), .en(adv), .din(sq3_in[i]), .dout(sq3[i]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb3[0] <= s15_fin;
      for (int i = 1; i < rdu_pkg::SqrtSteps; i++) begin
        sb3[i] <= sb3[i-1];
      end
    end
  end

  // Rounded dividends mag * 2^14 + len / 2.
  logic [44:0] s16_dv [3];
  logic [31:0] s16_len;
  tag_t        s16_tag;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s16_dv[i] <= {1'b0, sb3[SL].mg[i], 14'd0} + 45'(sq3[SL].root[31:1]);
      end
      s16_len <= sq3[SL].root;
      s16_tag <= '{sgn: sb3[SL].sgn, bad: sb3[SL].bad, zero: sb3[SL].zero};
    end
  end

  // Three output divider chains; the top dividend bits already sit below len.
  rdu_pkg::div_t dq_in [3][rdu_pkg::NormDivSteps];
  rdu_pkg::div_t dq    [3][rdu_pkg::NormDivSteps];
  tag_t          sb4   [rdu_pkg::NormDivSteps];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dq_in[l][0] = '{rem: {2'b00, s16_dv[l][44:15]}, den: s16_len,
                      num: {s16_dv[l][14:0], 17'd0}, quo: 32'd0};
      for (int i = 1; i < rdu_pkg::NormDivSteps; i++) begin
        dq_in[l][i] = dq[l][i-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar i = 0; i < rdu_pkg::NormDivSteps; i++) begin : g_div
      rdu_div_cell u_cell (.clk(clk), .en(adv), .din(dq_in[l][i]), .dout(dq[l][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb4[0] <= s16_tag;
      for (int i = 1; i < rdu_pkg::NormDivSteps; i++) begin
        sb4[i] <= sb4[i-1];
      end
    end
  end

  // Apply signs and the reject and zero cases, then register the result.
  rdu_pkg::res_t    res_next;
  logic [2:0][15:0] lane;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lane[l] = {1'b0, dq[l][DL].quo[14:0]};
      if (sb4[DL].sgn[l]) begin
        lane[l] = 16'(-lane[l]);
      end
      if (sb4[DL].bad || sb4[DL].zero) begin
        lane[l] = 16'd0;
      end
    end
    res_next.out_x     = lane[0];
    res_next.out_y     = lane[1];
    res_next.out_z     = lane[2];
    res_next.valid_res = !sb4[DL].bad;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  // Result properties checked by the assertions below.
  logic res_zero;
  logic res_bound;

  always_comb begin
    res_zero  = (res.out_x == 16'sd0) && (res.out_y == 16'sd0) && (res.out_z == 16'sd0);
    res_bound = (res.out_x <= 16'sd16384) && (res.out_x >= -16'sd16384) &&
                (res.out_y <= 16'sd16384) && (res.out_y >= -16'sd16384) &&
                (res.out_z <= 16'sd16384) && (res.out_z >= -16'sd16384);
  end

  // Assertions.
`include "refract_direction_unit_defines.svh"

  `RDU_ASSERT_NOW(a_reject_is_zero, clk, rst, res_valid && !res.valid_res, res_zero)
  `RDU_ASSERT_NOW(a_unit_bound, clk, rst, res_valid && res.valid_res, res_bound)
  `RDU_ASSERT_NEXT(a_transfer_enters, clk, rst, ray_valid && !ray_stall, v1[0])

endmodule

`default_nettype wire

// ===== hw/rtl/rdu_div_cell.sv =====
// ---------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit per cycle while enabled and hands the partial state onward.
// ---------------------------------------------------------------------------
`default_nettype none

module rdu_div_cell (
  input  logic          clk,
  input  logic          en,
  input  rdu_pkg::div_t din,
  output rdu_pkg::div_t dout
);

  rdu_pkg::div_t dout_next;
  logic [32:0]   trial;
  logic          take;

  // Bring down the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    trial          = {din.rem, din.num[31]};
    take           = (trial >= {1'b0, din.den});
    dout_next.den  = din.den;
    dout_next.num  = {din.num[30:0], 1'b0};
    dout_next.quo  = {din.quo[30:0], take};
    dout_next.rem  = take ? 32'(trial - {1'b0, din.den}) : trial[31:0];
  end

  // Cell register.
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rdu_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// Square root cell
// Produces one root bit per cycle while enabled from two radicand bits.
// ---------------------------------------------------------------------------
`default_nettype none

module rdu_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  rdu_pkg::sqrt_t din,
  output rdu_pkg::sqrt_t dout
);

  rdu_pkg::sqrt_t dout_next;
  logic [34:0]    rem2;
  logic [34:0]    trial;
  logic           take;

  // Shift in two radicand bits and try the root with a one appended.
  always_comb begin
    rem2           = {din.rem[32:0], din.rad[63:62]};
    trial          = {1'b0, din.root, 2'b01};
    take           = (rem2 >= trial);
    dout_next.rad  = {din.rad[61:0], 2'b00};
    dout_next.rem  = take ? (rem2 - trial) : rem2;
    dout_next.root = {din.root[30:0], take};
  end

  // Cell register.
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire
